// ===== rtl/ptrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ptrc_pkg: shared types and constants for the paper tape reader controller
// Mode and function codes, anomaly codes, item layouts and reset values.
// ----------------------------------------------------------------------------
package ptrc_pkg;

  // Item kinds carried in s_tuser
  localparam logic [2:0] MODE_CONTROL = 3'd0;
  localparam logic [2:0] MODE_SKIP    = 3'd1;
  localparam logic [2:0] MODE_READ    = 3'd2;
  localparam logic [2:0] MODE_MASK    = 3'd3;
  localparam logic [2:0] MODE_TAPE    = 3'd4;
  localparam logic [2:0] MODE_CLEAR   = 3'd5;

  // Function codes (s_tdata bits 2..0)
  localparam logic [2:0] FC_START      = 3'd0;
  localparam logic [2:0] FC_STOP       = 3'd1;
  localparam logic [2:0] FC_SKIP_READY = 3'd0;
  localparam logic [2:0] FC_SKIP_NOINT = 3'd4;

  // Anomaly codes
  localparam logic [1:0] ANOM_NONE    = 2'd0;
  localparam logic [1:0] ANOM_OVERRUN = 2'd1;
  localparam logic [1:0] ANOM_ILLEGAL = 2'd2;

  localparam int          DEF_MAX_PENDING   = 15;
  localparam logic [15:0] RETRY_LIMIT_RESET = 16'd1000;
  localparam logic [15:0] RETRY_COUNT_MAX   = 16'hffff;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] function_code;
    logic       mask_bit;
    logic [7:0] tape_byte;
    logic       tape_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       skip;
    logic       interrupt_line;
    logic       schedule_char;
    logic       new_tape_request;
    logic [1:0] anomaly;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/paper_tape_reader_controller_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// paper_tape_reader_controller_top: paper tape reader interface controller
// Handles bus commands, skip tests, reads, mask writes and tape events,
// keeping the reader flags and producing one result item per input item.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata command/tape
//  m_      | out | m_tvalid/m_tready  | m_tdata status and read data
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data end_retry_limit
//
//  One item per cycle sustained while results are taken. Two register
//  stages: the input register, then one pass of flag-update logic into
//  the result register, which an item enters once that is free or being taken.
//  A result left waiting while the input register is full holds s_tready
//  low; an empty input register still takes an item.
//  rst (synchronous) clears all reader flags and sets the retry limit to 1000.
//  cfg_ready is always high; writes are expected only while idle.
//
module paper_tape_reader_controller_top #(
  parameter int MAX_PENDING = ptrc_pkg::DEF_MAX_PENDING
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input items
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [2:0] function_code, [3] mask_bit, [11:4] tape_byte, [12] tape_end
  input  wire logic [ptrc_pkg::IN_DATA_W-1:0] s_tdata,
  // [2:0] mode
  input  wire logic [2:0]                     s_tuser,
  // result items
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [7:0] read_data, [8] skip, [9] interrupt_line, [10] schedule_char,
  // [11] new_tape_request, [13:12] anomaly
  output logic [ptrc_pkg::OUT_DATA_W-1:0]     m_tdata,
  // configuration
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [15:0]                    cfg_data
);

  localparam int          PW     = $clog2(MAX_PENDING + 1);
  localparam logic [PW-1:0] PEND_MAX = PW'(MAX_PENDING);

  // ---------------- configuration ----------------
  logic [15:0] end_retry_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_retry_limit <= ptrc_pkg::RETRY_LIMIT_RESET;
    end else if (cfg_valid) begin
      end_retry_limit <= cfg_data;
    end
  end

  // ---------------- input register ----------------
  logic               in_valid;
  ptrc_pkg::in_item_t in_item;
  logic               advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.mode          <= s_tuser;
      in_item.function_code <= s_tdata[2:0];
      in_item.mask_bit      <= s_tdata[3];
      in_item.tape_byte     <= s_tdata[11:4];
      in_item.tape_end      <= s_tdata[12];
    end
  end

  // ---------------- reader state ----------------
  logic          char_ready,      char_ready_next;
  logic [7:0]    char_buffer,     char_buffer_next;
  logic          int_mask,        int_mask_next;
  logic          at_tape_end,     at_tape_end_next;
  logic [15:0]   end_retry_count, end_retry_count_next;
  logic          running,         running_next;
  logic          skip_next_event, skip_next_event_next;
  logic [PW-1:0] pending_events,  pending_events_next;
  logic          tape_loaded,     tape_loaded_next;
  ptrc_pkg::out_item_t res;

  // Flag update for one item; ordering mirrors the command semantics, so
  // later assignments see earlier ones within the same item.
  always_comb begin
    char_ready_next      = char_ready;
    char_buffer_next     = char_buffer;
    int_mask_next        = int_mask;
    at_tape_end_next     = at_tape_end;
    end_retry_count_next = end_retry_count;
    running_next         = running;
    skip_next_event_next = skip_next_event;
    pending_events_next  = pending_events;
    tape_loaded_next     = tape_loaded;
    res                  = '0;

    case (in_item.mode)
      ptrc_pkg::MODE_CONTROL: begin
        if (in_item.function_code == ptrc_pkg::FC_START) begin
          // start at end of tape unloads it first
          if (at_tape_end) tape_loaded_next = 1'b0;
          if (!tape_loaded_next) begin
            res.new_tape_request = 1'b1;
            tape_loaded_next     = 1'b1;
            at_tape_end_next     = 1'b0;
            end_retry_count_next = '0;
          end
          if (!running) begin
            res.schedule_char = 1'b1;
            if (pending_events < PEND_MAX) pending_events_next = pending_events + 1'b1;
            running_next = 1'b1;
          end
        end else if (in_item.function_code == ptrc_pkg::FC_STOP) begin
          running_next = 1'b0;
          // a character already timed will still arrive: drop it
          if (pending_events != '0) skip_next_event_next = 1'b1;
        end else begin
          res.anomaly = ptrc_pkg::ANOM_ILLEGAL;
        end
      end
      ptrc_pkg::MODE_SKIP: begin
        if (in_item.function_code == ptrc_pkg::FC_SKIP_READY) begin
          res.skip = char_ready;
        end else if (in_item.function_code == ptrc_pkg::FC_SKIP_NOINT) begin
          res.skip = !(char_ready && int_mask);
        end else begin
          res.anomaly = ptrc_pkg::ANOM_ILLEGAL;
        end
      end
      ptrc_pkg::MODE_READ: begin
        res.skip = char_ready;
        if (char_ready) begin
          res.read_data   = char_buffer;
          char_ready_next = 1'b0;
        end else if (at_tape_end) begin
          if (end_retry_count != ptrc_pkg::RETRY_COUNT_MAX) begin
            end_retry_count_next = end_retry_count + 16'd1;
          end
          // too many failed reads: reload the tape and restart
          if (end_retry_count_next > end_retry_limit) begin
            res.new_tape_request = 1'b1;
            tape_loaded_next     = 1'b1;
            at_tape_end_next     = 1'b0;
            end_retry_count_next = '0;
            res.schedule_char    = 1'b1;
            if (pending_events < PEND_MAX) pending_events_next = pending_events + 1'b1;
            running_next = 1'b1;
          end
        end
      end
      ptrc_pkg::MODE_MASK: begin
        int_mask_next = in_item.mask_bit;
      end
      ptrc_pkg::MODE_TAPE: begin
        if (pending_events != '0) pending_events_next = pending_events - 1'b1;
        if (!skip_next_event) begin
          if (char_ready) res.anomaly = ptrc_pkg::ANOM_OVERRUN;
          if (in_item.tape_end) begin
            at_tape_end_next     = 1'b1;
            end_retry_count_next = '0;
          end else begin
            char_buffer_next  = in_item.tape_byte;
            char_ready_next   = 1'b1;
            res.schedule_char = 1'b1;
            if (pending_events_next < PEND_MAX) begin
              pending_events_next = pending_events_next + 1'b1;
            end
          end
        end
        skip_next_event_next = 1'b0;
      end
      ptrc_pkg::MODE_CLEAR: begin
        char_ready_next      = 1'b0;
        char_buffer_next     = '0;
        int_mask_next        = 1'b0;
        at_tape_end_next     = 1'b0;
        end_retry_count_next = '0;
        running_next         = 1'b0;
        skip_next_event_next = 1'b0;
        pending_events_next  = '0;
        tape_loaded_next     = 1'b0;
      end
      default: begin
      end
    endcase

    res.interrupt_line = char_ready_next & int_mask_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_ready      <= 1'b0;
      char_buffer     <= '0;
      int_mask        <= 1'b0;
      at_tape_end     <= 1'b0;
      end_retry_count <= '0;
      running         <= 1'b0;
      skip_next_event <= 1'b0;
      pending_events  <= '0;
      tape_loaded     <= 1'b0;
    end else if (advance) begin
      char_ready      <= char_ready_next;
      char_buffer     <= char_buffer_next;
      int_mask        <= int_mask_next;
      at_tape_end     <= at_tape_end_next;
      end_retry_count <= end_retry_count_next;
      running         <= running_next;
      skip_next_event <= skip_next_event_next;
      pending_events  <= pending_events_next;
      tape_loaded     <= tape_loaded_next;
    end
  end

  // ---------------- result register ----------------
  ptrc_pkg::out_item_t out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_item <= res;
  end

  assign m_tdata = {2'b00, out_item.anomaly, out_item.new_tape_request,
                    out_item.schedule_char, out_item.interrupt_line,
                    out_item.skip, out_item.read_data};

  // ---------------- assertions ----------------
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending_events <= PEND_MAX)
    else $error("pending count above its limit");

  a_irq_tracks_state: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_item.interrupt_line == (char_ready & int_mask)))
    else $error("held interrupt line disagrees with reader flags");

  a_anomaly_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_item.anomaly != 2'd3))
    else $error("undefined anomaly code");

  a_retry_at_end: assert property (@(posedge clk) disable iff (rst)
    (end_retry_count != '0) |-> at_tape_end)
    else $error("retry count nonzero away from end of tape");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(out_item))
    else $error("stalled result overwritten");

endmodule
`default_nettype wire
